[rtl/lgge_pkg.sv]
// shared types and constants for the life grid generation engine
package lgge_pkg;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;

	localparam int ROW_AW = $clog2(GRID_ROWS);
	localparam int COL_AW = $clog2(GRID_COLS);
	localparam int CNT_W  = $clog2(GRID_ROWS + 1);

	// neighbor counts of the b3/s23 rule
	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;

	// sweep cycle at which the first new row is complete
	localparam int SWEEP_FIRST_WR = 3;
	// distance between the row being read and the row being written
	localparam int SWEEP_WR_LAG   = 2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_SWEEP
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic cell_exec;
		logic sweep_run;
	} lgge_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} lgge_status_t;

endpackage

[rtl/lgge_ram.sv]
// generic single write port ram with registered read
module lgge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/lgge_ctrl.sv]
// controller state machine for the life grid generation engine
module lgge_ctrl import lgge_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [1:0]   operation,
	input  lgge_status_t status,
	output lgge_cmd_t    cmd,
	output logic         busy
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					if (operation == OP_STEP) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_CELL;
					end
				end
			end
			ST_CELL: begin
				cmd.cell_exec = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_SWEEP: begin
				cmd.sweep_run = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/lgge_datapath.sv]
// grid storage, row-wide neighbor logic and result register
module lgge_datapath import lgge_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lgge_cmd_t    cmd,
	output lgge_status_t status,
	input  logic [1:0]   operation,
	input  logic [5:0]   row_index,
	input  logic [5:0]   column_index,
	input  logic         write_alive,
	output logic         done,
	output logic         read_alive,
	output logic [1:0]   done_operation
);

	function automatic logic [GRID_COLS-1:0] life_next(
		input logic [GRID_COLS-1:0] up,
		input logic [GRID_COLS-1:0] mid,
		input logic [GRID_COLS-1:0] dn
	);
		logic [GRID_COLS-1:0] res;
		logic [3:0]           n;
		res = '0;
		for (int c = 1; c < GRID_COLS - 1; c++) begin
			n = 4'(up[c-1]) + 4'(up[c]) + 4'(up[c+1])
			  + 4'(mid[c-1]) + 4'(mid[c+1])
			  + 4'(dn[c-1]) + 4'(dn[c]) + 4'(dn[c+1]);
			res[c] = (n == 4'(BIRTH_COUNT)) || (mid[c] && (n == 4'(SURVIVE_COUNT)));
		end
		return res;
	endfunction

	// captured command word
	logic [1:0]            op_q;
	logic [COL_AW-1:0]     col_q;
	logic                  val_q;
	logic                  inside_q;
	logic [ROW_AW-1:0]     row_q;

	logic [CNT_W-1:0]      sweep_cnt_q;
	logic [GRID_COLS-1:0]  upper_q;
	logic [GRID_COLS-1:0]  middle_q;

	// a row whose valid bit is clear reads as all dead
	logic [GRID_ROWS-1:0]  valid_q;
	logic                  rd_valid_q;

	logic [ROW_AW-1:0]     raddr;
	logic [GRID_COLS-1:0]  ram_rdata;
	logic [GRID_COLS-1:0]  row_cur;
	logic                  ram_we;
	logic [ROW_AW-1:0]     ram_waddr;
	logic [GRID_COLS-1:0]  ram_wdata;
	logic [GRID_COLS-1:0]  row_mod;
	logic                  in_grid;
	logic                  sweep_wr;

	logic                  done_q;
	logic                  read_alive_q;
	logic [1:0]            done_op_q;

	assign in_grid = (32'(row_index) < 32'(GRID_ROWS))
	              && (32'(column_index) < 32'(GRID_COLS));

	assign status.sweep_last = (sweep_cnt_q == CNT_W'(GRID_ROWS));

	assign raddr   = cmd.capture ? ROW_AW'(row_index) : ROW_AW'(sweep_cnt_q);
	assign row_cur = rd_valid_q ? ram_rdata : '0;

	always_comb begin
		row_mod        = row_cur;
		row_mod[col_q] = val_q;
	end

	assign sweep_wr = cmd.sweep_run && (sweep_cnt_q >= CNT_W'(SWEEP_FIRST_WR));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = row_mod;
		if (sweep_wr) begin
			ram_we    = 1'b1;
			ram_waddr = ROW_AW'(sweep_cnt_q - CNT_W'(SWEEP_WR_LAG));
			ram_wdata = life_next(upper_q, middle_q, row_cur);
		end else if (cmd.cell_exec && (op_q == OP_WRITE) && inside_q) begin
			ram_we = 1'b1;
		end
	end

	lgge_ram #(
		.WIDTH (GRID_COLS),
		.DEPTH (GRID_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= operation;
			row_q    <= ROW_AW'(row_index);
			col_q    <= COL_AW'(column_index);
			val_q    <= write_alive;
			inside_q <= in_grid;
		end
		// window of unmodified rows: the row above the one being computed and that row itself
		if (cmd.sweep_run) begin
			upper_q  <= middle_q;
			middle_q <= row_cur;
		end
		read_alive_q <= cmd.cell_exec && (op_q == OP_READ) && inside_q && row_cur[col_q];
		done_op_q    <= op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
			sweep_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[raddr];
			done_q     <= cmd.cell_exec || (cmd.sweep_run && status.sweep_last);
			if (cmd.capture) begin
				sweep_cnt_q <= '0;
			end else if (cmd.sweep_run) begin
				sweep_cnt_q <= sweep_cnt_q + CNT_W'(1);
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			// border rows end every generation dead
			if (cmd.sweep_run && status.sweep_last) begin
				valid_q[0]             <= 1'b0;
				valid_q[GRID_ROWS - 1] <= 1'b0;
			end
		end
	end

	assign done           = done_q;
	assign read_alive     = read_alive_q;
	assign done_operation = done_op_q;

endmodule

[rtl/life_grid_generation_engine_top.sv]
// top level of the life grid generation engine
//
// a command word is taken on a rising edge with start high and busy low:
// operation 0 writes one cell, 2 reads one cell, 1 advances the whole grid
// by one b3/s23 generation; code 3 changes nothing. every word gives one
// result, shown for a single cycle with done high: read_alive carries the
// cell for a read (zero otherwise) and done_operation echoes the operation.
// the receiver cannot hold results off.
// cell writes, reads and the unused code pass through the cell state with
// busy high, and done is registered from that state.
// a generation streams the grid through the row memory's read port, one row
// per cycle, writing each new row once the row below it has been read; busy
// stays high through the sweep state, and done is registered from its last
// row. a new word may be accepted in the cycle done shows.
// reset clears the per-row valid bits at once, so the grid reads all dead
// right after reset with no clearing pass.
module life_grid_generation_engine_top import lgge_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [5:0] row_index,
	input  logic [5:0] column_index,
	input  logic       write_alive,
	output logic       done,
	output logic       read_alive,
	output logic [1:0] done_operation
);

	lgge_cmd_t    cmd;
	lgge_status_t status;

	lgge_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	lgge_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (operation),
		.row_index      (row_index),
		.column_index   (column_index),
		.write_alive    (write_alive),
		.done           (done),
		.read_alive     (read_alive),
		.done_operation (done_operation)
	);

endmodule

[rtl/lgge_checker.sv]
// port-level checks for the life grid generation engine and their binding
module lgge_checker import lgge_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       read_alive,
	input logic [1:0] done_operation
);

	// every accepted word raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result always closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result without a preceding busy period");

	// only reads return a live cell
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && read_alive |-> done_operation == OP_READ)
		else $error("read_alive set on a non-read result");

	// a generation result checks the start of its busy period against the row count
	a_step_length: assert property (@(posedge clk) disable iff (!arst_n)
		done && (done_operation == OP_STEP)
			|-> $past(busy, GRID_ROWS + 1) && !$past(busy, GRID_ROWS + 2))
		else $error("generation length differs from the row count");

endmodule

bind life_grid_generation_engine_top lgge_checker u_lgge_checker (.*);
